### sv/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types, status codes and a helper function shared by the byte-serial
// decoder for the original 31-bit (1 to 6 byte) UTF-8 form.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_OVERLONG  = 3'd4,
        ST_SURROGATE = 3'd5
    } t_status;

    localparam int unsigned CpWidth  = 31;
    localparam int unsigned CntWidth = 3;

    // Surrogate window, half-open
    localparam logic [CpWidth-1:0] SurrLow  = 31'h0000_d800;
    localparam logic [CpWidth-1:0] SurrHigh = 31'h0000_e000;

    // One input item: a raw byte and the last-byte flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        t_status            status;
    } t_out_item;

    // Smallest value that needs the given number of continuation bytes
    function automatic logic [CpWidth-1:0] min_value(input logic [CntWidth-1:0] n);
        logic [CpWidth-1:0] v;
        case (n)
            3'd1:    v = 31'h0000_0080;
            3'd2:    v = 31'h0000_0800;
            3'd3:    v = 31'h0001_0000;
            3'd4:    v = 31'h0020_0000;
            3'd5:    v = 31'h0400_0000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Byte-serial decoder for 1 to 6 byte UTF-8 sequences (31-bit code points).
// Emits one result per finished sequence or per failed string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one byte per
//   item with an end-of-string flag. Output channel (o_out_valid /
//   i_out_ready / o_out_data) carries a code point and a status.
//   An ASCII byte or the last byte of a sequence yields a result; lead and
//   middle continuation bytes yield none. After an error one error item is
//   sent and bytes are dropped through the next end-of-string byte.
//   An accepted item lands in the input register, and its result is loaded
//   from there into the output register once that register is free.
//   Throughput: one byte per cycle unless a result waits on a stalled output;
//   the decode logic between the input and output registers is a shift,
//   masks and compares.
//   Stall: while the output register holds an untaken result, an input item
//   that produces no result still advances; one that produces a result
//   waits in the input register, and o_in_ready drops when it is full.
//   Reset (synchronous, active low) empties both registers and returns the
//   decoder to expecting a lead byte, not discarding.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  u8sd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output u8sd_pkg::t_out_item o_out_data
);
    import u8sd_pkg::*;

    // Input register
    logic     r_in_valid;
    t_in_item r_in;

    // Decoder state
    logic [CpWidth-1:0]  r_acc,  n_acc;
    logic [CntWidth-1:0] r_rem,  n_rem;
    logic [CntWidth-1:0] r_len,  n_len;
    logic                r_disc, n_disc;

    // Output register
    logic      r_out_valid;
    t_out_item r_out;

    // Decode results
    logic               res_valid;
    logic [CpWidth-1:0] res_cp;
    t_status            res_st;
    logic [CpWidth-1:0] acc_shift;
    logic [CntWidth-1:0] rem_dec;
    logic [7:0]         b;
    logic               eos;

    logic out_free;
    logic consume;

    assign b         = r_in.data_byte;
    assign eos       = r_in.end_of_string;
    assign acc_shift = {r_acc[CpWidth-7:0], b[5:0]};
    assign rem_dec   = r_rem - 3'd1;

    // Decode one byte against the current sequence state
    always_comb begin
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_len     = r_len;
        n_disc    = r_disc;
        res_valid = 1'b0;
        res_cp    = '0;
        res_st    = ST_OK;
        if (r_disc) begin
            // drop bytes through end of string
            if (eos) begin
                n_disc = 1'b0;
                n_acc  = '0;
                n_rem  = '0;
                n_len  = '0;
            end
        end else if (r_rem == '0) begin
            // lead byte expected
            n_acc = '0;
            n_rem = '0;
            n_len = '0;
            if (b[7] == 1'b0) begin
                res_valid = 1'b1;
                res_cp    = {{(CpWidth-8){1'b0}}, b};
            end else if (b[6] == 1'b0 || b[7:1] == 7'h7f) begin
                res_valid = 1'b1;
                res_st    = ST_BAD_LEAD;
                n_disc    = ~eos;
            end else if (eos) begin
                res_valid = 1'b1;
                res_st    = ST_TRUNCATED;
            end else if (b[5] == 1'b0) begin
                n_acc = {{(CpWidth-5){1'b0}}, b[4:0]};
                n_rem = 3'd1;
            end else if (b[4] == 1'b0) begin
                n_acc = {{(CpWidth-4){1'b0}}, b[3:0]};
                n_rem = 3'd2;
            end else if (b[3] == 1'b0) begin
                n_acc = {{(CpWidth-3){1'b0}}, b[2:0]};
                n_rem = 3'd3;
            end else if (b[2] == 1'b0) begin
                n_acc = {{(CpWidth-2){1'b0}}, b[1:0]};
                n_rem = 3'd4;
            end else begin
                n_acc = {{(CpWidth-1){1'b0}}, b[0]};
                n_rem = 3'd5;
            end
            if (res_valid == 1'b0) begin
                n_len = n_rem;
            end
        end else if (b[7:6] != 2'b10) begin
            // bad continuation byte
            n_acc     = '0;
            n_rem     = '0;
            n_len     = '0;
            res_valid = 1'b1;
            res_st    = ST_BAD_CONT;
            n_disc    = ~eos;
        end else if (rem_dec != '0) begin
            // middle continuation byte
            if (eos) begin
                n_acc     = '0;
                n_rem     = '0;
                n_len     = '0;
                res_valid = 1'b1;
                res_st    = ST_TRUNCATED;
            end else begin
                n_acc = acc_shift;
                n_rem = rem_dec;
            end
        end else begin
            // final continuation byte: range checks, then emit
            n_acc     = '0;
            n_rem     = '0;
            n_len     = '0;
            res_valid = 1'b1;
            if (acc_shift < min_value(r_len)) begin
                res_st = ST_OVERLONG;
                n_disc = ~eos;
            end else if (acc_shift >= SurrLow && acc_shift < SurrHigh) begin
                res_st = ST_SURROGATE;
                n_disc = ~eos;
            end else begin
                res_cp = acc_shift;
            end
        end
    end

    // Handshake between the two registers
    assign out_free   = ~r_out_valid | i_out_ready;
    assign consume    = r_in_valid & (~res_valid | out_free);
    assign o_in_ready = ~r_in_valid | consume;

    // Load the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Advance decoder state on each consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_rem  <= '0;
            r_len  <= '0;
            r_disc <= 1'b0;
        end else if (consume) begin
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_len  <= n_len;
            r_disc <= n_disc;
        end
    end

    // Load or drain the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (consume && res_valid) begin
            r_out.code_point <= res_cp;
            r_out.status     <= res_st;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### sv/u8sd_checker.sv
// ----------------------------------------------------------------------------
// u8sd_checker
// Port-level checks for utf8_stream_decoder_unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input u8sd_pkg::t_in_item  i_in_data,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input u8sd_pkg::t_out_item o_out_data
);
    import u8sd_pkg::*;

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Hold an input item until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("waiting input item changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output item changed");

    // Error items carry a zero code point
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.code_point == '0)
        else $error("error item with nonzero code point");

    // Never pass a surrogate as ok
    a_no_surr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_OK |->
            !(o_out_data.code_point >= SurrLow && o_out_data.code_point < SurrHigh))
        else $error("surrogate emitted with ok status");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_u8sd_checker (.*);

`default_nettype wire

### tb/utf8_stream_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit_test
// Self-checking bench for the byte-serial 31-bit UTF-8 decoder. Strings of
// encoded code points, most of them well formed and some broken, overlong
// or surrogate, are fed one byte per item. A scoreboard predicts each
// result from its own copy of the decode state and checks the output items
// in order. Sender and receiver stall at random in two patterns, then run
// without stalls.
// ----------------------------------------------------------------------------

module utf8_stream_decoder_unit_test;
    import u8sd_pkg::*;

    // Predicts the decoder's results and checks what comes out of it
    class decode_tracker;
        t_out_item       pending_points [$];
        logic [30:0]     acc;
        logic [2:0]      cont_left;
        logic [2:0]      cont_total;
        bit              dropping;
        int              mismatches;
        int              bytes_fed;
        int              bytes_decoded;
        int              results_checked;
        int              status_hits [6];

        function new();
            clear_seq();
            dropping = 1'b0;
            mismatches = 0;
            bytes_fed = 0;
            bytes_decoded = 0;
            results_checked = 0;
            foreach (status_hits[k]) status_hits[k] = 0;
        endfunction

        function void clear_seq();
            acc = '0;
            cont_left = '0;
            cont_total = '0;
        endfunction

        // Lowest value that really needs n continuation bytes
        function logic [30:0] shortest_floor(input logic [2:0] n);
            return (n == 3'd1) ? 31'h80 : (31'd1 << (5 * n + 1));
        endfunction

        function void push_point(input logic [30:0] cp, input t_status st);
            t_out_item r;
            r.code_point = cp;
            r.status = st;
            pending_points.insert(pending_points.size(), r);
        endfunction

        // Any error idles the sequence; drop the rest unless this was the last byte
        function void push_error(input t_status st, input logic eos);
            clear_seq();
            dropping = !eos;
            push_point('0, st);
        endfunction

        function int pending_count();
            return pending_points.size();
        endfunction

        // Advance the predicted state by one accepted byte
        function void take_byte(input t_in_item item);
            logic [7:0]  b;
            logic        eos;
            logic [2:0]  n;
            logic [30:0] cp;
            b = item.data_byte;
            eos = item.end_of_string;
            bytes_fed++;
            if (dropping) begin
                if (eos) begin
                    dropping = 1'b0;
                    clear_seq();
                end
                return;
            end
            bytes_decoded++;
            if (cont_left == 3'd0) begin
                if (b < 8'h80) begin
                    clear_seq();
                    push_point({23'd0, b}, ST_OK);
                end else if (b < 8'hc0 || b >= 8'hfe) begin
                    push_error(ST_BAD_LEAD, eos);
                end else begin
                    if (b < 8'he0)      n = 3'd1;
                    else if (b < 8'hf0) n = 3'd2;
                    else if (b < 8'hf8) n = 3'd3;
                    else if (b < 8'hfc) n = 3'd4;
                    else                n = 3'd5;
                    if (eos) begin
                        push_error(ST_TRUNCATED, 1'b1);
                    end else begin
                        acc = {23'd0, b & (8'h7f >> (n + 3'd1))};
                        cont_left = n;
                        cont_total = n;
                    end
                end
            end else if (b[7:6] != 2'b10) begin
                push_error(ST_BAD_CONT, eos);
            end else begin
                acc = {acc[24:0], b[5:0]};
                cont_left = cont_left - 3'd1;
                if (cont_left != 3'd0) begin
                    if (eos) push_error(ST_TRUNCATED, 1'b1);
                end else begin
                    cp = acc;
                    n = cont_total;
                    clear_seq();
                    if (cp < shortest_floor(n))
                        push_error(ST_OVERLONG, eos);
                    else if (cp >= SurrLow && cp < SurrHigh)
                        push_error(ST_SURROGATE, eos);
                    else
                        push_point(cp, ST_OK);
                end
            end
        endfunction

        // Print one mismatch line (the first hundred) and count every one
        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= 100) $display("MISMATCH @%0t: %s", $time, what);
        endtask

        // Compare one output item with the oldest prediction
        task match_result(input t_out_item got);
            t_out_item want;
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("unexpected item cp=%h status=%0d",
                                          got.code_point, got.status));
                return;
            end
            want = pending_points.pop_front();
            results_checked++;
            status_hits[int'(want.status)]++;
            if (got.code_point !== want.code_point)
                report_mismatch($sformatf("code_point %h, want %h (status %0d)",
                                          got.code_point, want.code_point, want.status));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d (cp %h)",
                                          got.status, want.status, want.code_point));
        endtask

        // Flag every prediction that never showed up
        task drain_check();
            t_out_item want;
            while (pending_points.size() != 0) begin
                want = pending_points.pop_front();
                report_mismatch($sformatf("missing item cp=%h status=%0d",
                                          want.code_point, want.status));
            end
        endtask
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    t_in_item      in_data;
    logic          in_ready;
    logic          out_valid;
    logic          out_ready = 1'b0;
    t_out_item     out_data;

    int            send_idle_pct = 34;
    int            recv_idle_pct = 47;
    bit            in_taken = 1'b0;
    logic [7:0]    str_buf [$];
    int            strings_sent = 0;
    decode_tracker tracker;

    utf8_stream_decoder_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Sample both handshakes at the rising edge
    always @(posedge clk) begin
        in_taken = rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) tracker.match_result(out_data);
            if (in_valid && in_ready) tracker.take_byte(in_data);
        end
    end

    // Stall the output side at random
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Payload bits carried by an encoding of len bytes
    function automatic int payload_bits(input int len);
        return (len == 1) ? 7 : 5 * len + 1;
    endfunction

    function automatic int unsigned bits_mask(input int len);
        return (32'd1 << payload_bits(len)) - 32'd1;
    endfunction

    // Append cp encoded in exactly len bytes, overlong if cp is small
    function automatic void add_seq(input int unsigned cp, input int len);
        int unsigned lead;
        int          k;
        if (len == 1) begin
            str_buf.insert(str_buf.size(), 8'(cp & 32'h7f));
        end else begin
            lead = ((32'hff << (8 - len)) & 32'hff) |
                   ((cp >> (6 * (len - 1))) & (32'h7f >> len));
            str_buf.insert(str_buf.size(), 8'(lead));
            for (k = len - 2; k >= 0; k--)
                str_buf.insert(str_buf.size(), 8'(32'h80 | ((cp >> (6 * k)) & 32'h3f)));
        end
    endfunction

    // Drive one item and hold it until it is taken
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(negedge clk); while (!in_taken);
    endtask

    // Send the buffered bytes as one string, flagging the last byte
    task automatic send_string();
        int       k;
        t_in_item item;
        for (k = 0; k < str_buf.size(); k++) begin
            item.data_byte = str_buf[k];
            item.end_of_string = (k == str_buf.size() - 1);
            send_item(item);
        end
        strings_sent++;
    endtask

    // Send a short fixed string, first byte in the top bits used
    task automatic send_literal(input int count, input logic [47:0] packed_bytes);
        int k;
        str_buf.delete();
        for (k = count - 1; k >= 0; k--)
            str_buf.insert(str_buf.size(), packed_bytes[8 * k +: 8]);
        send_string();
    endtask

    // Build a random string: mostly clean sequences, some damaged or noise
    task automatic build_string();
        int nseq;
        int len;
        int pick;
        int pos;
        str_buf.delete();
        nseq = $urandom_range(1, 4);
        repeat (nseq) begin
            len = $urandom_range(1, 6);
            pick = $urandom_range(99);
            if (pick < 68)
                add_seq($urandom & bits_mask(len), len);
            else if (pick < 80 && len > 1)
                add_seq($urandom & bits_mask(len - 1), len);
            else if (pick < 90)
                add_seq(32'hd7ff + $urandom_range(32'h801),
                        ($urandom_range(3) == 0) ? 4 : 3);
            else if ($urandom_range(1) == 0)
                add_seq(bits_mask(len), len);
            else
                add_seq((len == 1) ? 0 : bits_mask(len - 1) + 1, len);
        end
        pick = $urandom_range(99);
        pos = $urandom_range(str_buf.size() - 1);
        if (pick < 70) begin
            // keep it clean
        end else if (pick < 78) begin
            str_buf[pos] = 8'($urandom);
        end else if (pick < 86) begin
            if (str_buf.size() > 1)
                repeat ($urandom_range(1, str_buf.size() - 1)) void'(str_buf.pop_back());
        end else if (pick < 92) begin
            str_buf.insert(pos, 8'($urandom));
        end else begin
            str_buf.delete();
            repeat ($urandom_range(1, 6)) str_buf.insert(str_buf.size(), 8'($urandom));
        end
    endtask

    task automatic random_phase(input int fed_goal);
        while (tracker.bytes_fed < fed_goal) begin
            build_string();
            send_string();
        end
    endtask

    initial begin
        int guard;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        tracker = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ASCII extremes
        send_literal(1, 48'h00);
        send_literal(1, 48'h7f);
        // shortest two-byte value and largest six-byte value
        send_literal(2, 48'hc280);
        send_literal(6, 48'hfd_bf_bf_bf_bf_bf);
        // bad lead on the last byte, then bad lead followed by a dropped byte
        send_literal(1, 48'h80);
        send_literal(2, 48'hfeff);
        // bad continuation, the rest of the string dropped
        send_literal(3, 48'he0_41_42);
        // lead byte cut off by the end of the string
        send_literal(1, 48'hf0);
        // sequence cut off in the middle
        send_literal(2, 48'he282);
        // overlong two-byte form
        send_literal(2, 48'hc080);
        // first surrogate
        send_literal(3, 48'hed_a0_80);

        random_phase(470);
        send_idle_pct = 47;
        recv_idle_pct = 34;
        random_phase(940);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(1400);

        // Let the last results drain, then run on idle before the final check
        in_valid <= 1'b0;
        guard = 0;
        while (tracker.pending_count() != 0 && guard < 10000) begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
        tracker.drain_check();

        $display("Fed %0d bytes in %0d strings, %0d decoded and the rest dropped;",
                 tracker.bytes_fed, strings_sent, tracker.bytes_decoded);
        $display("%0d results checked: ok %0d, bad lead %0d, bad cont %0d, %s%0d, %s%0d, %s%0d.",
                 tracker.results_checked,
                 tracker.status_hits[0], tracker.status_hits[1], tracker.status_hits[2],
                 "truncated ", tracker.status_hits[3], "overlong ", tracker.status_hits[4],
                 "surrogate ", tracker.status_hits[5]);
        if (tracker.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/u8sd_pkg.sv
sv/utf8_stream_decoder_unit.sv
sv/u8sd_checker.sv
tb/utf8_stream_decoder_unit_test.sv
